// ----- rtl/stt_pkg.sv -----
// Shared types and constants for the sparse triplet transpose block.
package stt_pkg;

  localparam int ROW_W       = 16;
  localparam int COL_W       = 6;
  localparam int VAL_W       = 32;
  localparam int CCOUNT_W    = 7;
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 16;

  // Column indexes are COL_W bits wide, so no more columns than this can occur.
  localparam int COL_LIMIT   = 2 ** COL_W;

  // Power of two, pointers wrap naturally.
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_ROW_COUNT    = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_COLUMN_COUNT = CFG_INDEX_W'(1);

  localparam logic [ROW_W-1:0]    ROW_COUNT_RESET    = 16'hFFFF;
  localparam logic [CCOUNT_W-1:0] COLUMN_COUNT_RESET = 7'd64;

  // Classified triplet as it travels from the front end to the back end.
  typedef struct packed {
    logic [ROW_W-1:0]        row;
    logic [COL_W-1:0]        col;
    logic signed [VAL_W-1:0] value;
    logic                    last;
    logic                    keep;
  } item_t;

  // Stored triplet.
  typedef struct packed {
    logic [COL_W-1:0]        col;
    logic [ROW_W-1:0]        row;
    logic signed [VAL_W-1:0] value;
  } elem_t;

  typedef enum logic [2:0] {
    B_LOAD,
    B_PREFIX,
    B_SCATTER,
    B_EMIT,
    B_EMPTY
  } bstate_t;

endpackage

// ----- rtl/sparse_triplet_transpose.sv -----
// Top level of the sparse triplet transpose: config registers, front end, queue, back end.
// Loading takes triplets while in_stall is low; a triplet without the last flag gives no result.
// After the last triplet: a prefix pass over the column counts, a scatter, then one result
// per cycle while out_stall is low; a matrix with no kept triplet gives one dropped result.
// Reset clears control, counts and config (rows 65535, columns 64); no clearing pass.
module sparse_triplet_transpose #(
  parameter int MAX_ELEMENTS = 64,
  parameter int MAX_COLUMNS  = 64
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [stt_pkg::ROW_W-1:0]            in_row,
  input  logic [stt_pkg::COL_W-1:0]            in_col,
  input  logic signed [stt_pkg::VAL_W-1:0]     in_value,
  input  logic                                 in_last,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [stt_pkg::COL_W-1:0]            out_row,
  output logic [stt_pkg::ROW_W-1:0]            out_col,
  output logic signed [stt_pkg::VAL_W-1:0]     out_value,
  output logic                                 out_last,
  output logic                                 dropped,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [stt_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [stt_pkg::CFG_DATA_W-1:0]       cfg_data
);

  logic [stt_pkg::ROW_W-1:0]    row_count;
  logic [stt_pkg::CCOUNT_W-1:0] column_count;

  logic           q_push;
  logic           q_full;
  logic           q_pop;
  logic           q_valid;
  stt_pkg::item_t q_item_in;
  stt_pkg::item_t q_item_out;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count    <= stt_pkg::ROW_COUNT_RESET;
      column_count <= stt_pkg::COLUMN_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        stt_pkg::REG_ROW_COUNT: begin
          row_count <= cfg_data[stt_pkg::ROW_W-1:0];
        end
        stt_pkg::REG_COLUMN_COUNT: begin
          column_count <= cfg_data[stt_pkg::CCOUNT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  stt_front #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .MAX_COLUMNS  (MAX_COLUMNS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_row       (in_row),
    .in_col       (in_col),
    .in_value     (in_value),
    .in_last      (in_last),
    .row_count    (row_count),
    .column_count (column_count),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_item       (q_item_in)
  );

  stt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_item_in),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_item  (q_item_out)
  );

  stt_back #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .MAX_COLUMNS  (MAX_COLUMNS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_item       (q_item_out),
    .q_pop        (q_pop),
    .column_count (column_count),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_row      (out_row),
    .out_col      (out_col),
    .out_value    (out_value),
    .out_last     (out_last),
    .dropped      (dropped)
  );

endmodule

// ----- rtl/stt_front.sv -----
// Front end: accepts triplets, range and capacity checks, hands them to the queue.
module stt_front #(
  parameter int MAX_ELEMENTS = 64,
  parameter int MAX_COLUMNS  = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [stt_pkg::ROW_W-1:0]           in_row,
  input  logic [stt_pkg::COL_W-1:0]           in_col,
  input  logic signed [stt_pkg::VAL_W-1:0]    in_value,
  input  logic                                in_last,
  input  logic [stt_pkg::ROW_W-1:0]           row_count,
  input  logic [stt_pkg::CCOUNT_W-1:0]        column_count,
  input  logic                                q_full,
  output logic                                q_push,
  output stt_pkg::item_t                      q_item
);

  localparam int CW = $clog2(MAX_ELEMENTS + 1);

  logic          item_valid;
  stt_pkg::item_t item;
  logic [CW-1:0] kept;
  logic          keep;
  logic          take;

  assign in_stall = item_valid && q_full;
  assign take     = in_valid && !in_stall;
  assign q_push   = item_valid && !q_full;
  assign q_item   = item;

  // kept mirrors the back end's stored count for the current matrix
  assign keep = (in_row < row_count)
             && ({1'b0, in_col} < column_count)
             && (32'(in_col) < MAX_COLUMNS)
             && (32'(kept) < MAX_ELEMENTS);

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      kept       <= '0;
    end else begin
      if (take) begin
        item_valid <= 1'b1;
        kept       <= in_last ? '0 : kept + CW'(keep);
      end else if (q_push) begin
        item_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item.row   <= in_row;
      item.col   <= in_col;
      item.value <= in_value;
      item.last  <= in_last;
      item.keep  <= keep;
    end
  end

endmodule

// ----- rtl/stt_queue.sv -----
// Short FIFO between the front end and the back end.
module stt_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  stt_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output stt_pkg::item_t pop_item
);

  localparam int QAW = $clog2(stt_pkg::QUEUE_DEPTH);
  localparam int QCW = $clog2(stt_pkg::QUEUE_DEPTH + 1);

  stt_pkg::item_t slots [stt_pkg::QUEUE_DEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QCW-1:0] fill;

  assign full     = (fill == QCW'(stt_pkg::QUEUE_DEPTH));
  assign valid    = (fill != '0);
  assign pop_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QAW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QAW'(1);
      end
      fill <= fill + QCW'(push) - QCW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

// ----- rtl/stt_back.sv -----
// Back end: element store, column counts, prefix pass, scatter and result emit.
module stt_back #(
  parameter int MAX_ELEMENTS = 64,
  parameter int MAX_COLUMNS  = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              q_valid,
  input  stt_pkg::item_t                    q_item,
  output logic                              q_pop,
  input  logic [stt_pkg::CCOUNT_W-1:0]      column_count,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [stt_pkg::COL_W-1:0]         out_row,
  output logic [stt_pkg::ROW_W-1:0]         out_col,
  output logic signed [stt_pkg::VAL_W-1:0]  out_value,
  output logic                              out_last,
  output logic                              dropped
);

  localparam int CW        = $clog2(MAX_ELEMENTS + 1);
  localparam int EAW       = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int CNT_DEPTH = (MAX_COLUMNS < stt_pkg::COL_LIMIT) ? MAX_COLUMNS
                                                               : stt_pkg::COL_LIMIT;
  localparam int CAW       = $clog2(CNT_DEPTH);
  localparam int PKW       = $clog2(CNT_DEPTH + 1);

  stt_pkg::bstate_t state;
  stt_pkg::bstate_t state_next;

  // memories
  stt_pkg::elem_t elem_mem [MAX_ELEMENTS];
  stt_pkg::elem_t out_mem  [MAX_ELEMENTS];
  logic [CW-1:0]  cnt_mem  [CNT_DEPTH];
  logic [CNT_DEPTH-1:0] cnt_vld;

  // count memory ports
  logic [CAW-1:0] cnt_raddr;
  logic           cnt_we;
  logic [CAW-1:0] cnt_waddr;
  logic [CW-1:0]  cnt_wdata;
  logic [CW-1:0]  cnt_rd;
  logic           cnt_rd_vld;
  logic [CW-1:0]  cnt_val;

  // matrix state
  logic [CW-1:0]  n;
  logic           discard;
  logic           pop_keep;

  // load pipeline
  logic           ld_wr;
  logic [CAW-1:0] ld_col;

  // prefix pass
  logic [PKW-1:0] pk;
  logic [PKW-1:0] pf_limit;
  logic           pf_rd;
  logic           pf_pend;
  logic [CAW-1:0] pf_addr;
  logic [CW-1:0]  sum;

  // scatter pipeline
  logic [CW-1:0]  sk;
  logic           sc_a;
  logic           sc_b;
  stt_pkg::elem_t elem_rd;
  stt_pkg::elem_t sc_elem;

  // emit
  logic [CW-1:0]  ek;
  logic           out_free;
  logic           emit_rd;
  logic           empty_ld;
  logic           clr;
  stt_pkg::elem_t odata;
  logic           olast;
  logic           odrop;

  assign q_pop    = (state == stt_pkg::B_LOAD) && q_valid;
  assign pop_keep = q_pop && q_item.keep;
  assign cnt_val  = cnt_rd_vld ? cnt_rd : '0;
  assign out_free = !out_valid || !out_stall;
  assign pf_limit = (32'(column_count) > CNT_DEPTH) ? PKW'(CNT_DEPTH)
                                                    : PKW'(column_count);
  assign pf_rd    = (state == stt_pkg::B_PREFIX) && !ld_wr && (pk < pf_limit);

  assign out_row   = odata.col;
  assign out_col   = odata.row;
  assign out_value = odata.value;
  assign out_last  = olast;
  assign dropped   = odrop;

  // count memory port selection; users are exclusive by state
  always_comb begin
    cnt_raddr = '0;
    cnt_we    = 1'b0;
    cnt_waddr = '0;
    cnt_wdata = '0;
    if (pop_keep) begin
      cnt_raddr = q_item.col[CAW-1:0];
    end else if (pf_rd) begin
      cnt_raddr = pk[CAW-1:0];
    end else if (sc_a) begin
      cnt_raddr = elem_rd.col[CAW-1:0];
    end
    if (ld_wr) begin
      cnt_we    = 1'b1;
      cnt_waddr = ld_col;
      cnt_wdata = cnt_val + CW'(1);
    end else if (pf_pend) begin
      cnt_we    = 1'b1;
      cnt_waddr = pf_addr;
      cnt_wdata = sum;
    end else if (sc_b) begin
      cnt_we    = 1'b1;
      cnt_waddr = sc_elem.col[CAW-1:0];
      cnt_wdata = cnt_val + CW'(1);
    end
  end

  // write-first read: a same-address write in this cycle is forwarded
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    if (cnt_we && (cnt_waddr == cnt_raddr)) begin
      cnt_rd <= cnt_wdata;
    end else begin
      cnt_rd <= cnt_mem[cnt_raddr];
    end
  end

  // entries not written since the last matrix read as zero
  always_ff @(posedge clk) begin
    if (rst || clr) begin
      cnt_vld    <= '0;
      cnt_rd_vld <= 1'b0;
    end else begin
      if (cnt_we) begin
        cnt_vld[cnt_waddr] <= 1'b1;
      end
      cnt_rd_vld <= (cnt_we && (cnt_waddr == cnt_raddr)) || cnt_vld[cnt_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (pop_keep) begin
      elem_mem[n[EAW-1:0]] <= '{col: q_item.col, row: q_item.row, value: q_item.value};
    end
    elem_rd <= elem_mem[sk[EAW-1:0]];
  end

  // scatter writes slot order, emit reads it back in sequence
  always_ff @(posedge clk) begin
    if (sc_b) begin
      out_mem[cnt_val[EAW-1:0]] <= sc_elem;
    end
    if (emit_rd) begin
      odata <= out_mem[ek[EAW-1:0]];
    end else if (empty_ld) begin
      odata <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_rd) begin
      olast <= (ek + CW'(1) == n);
      odrop <= discard;
    end else if (empty_ld) begin
      olast <= 1'b0;
      odrop <= 1'b1;
    end
    if (sc_a) begin
      sc_elem <= elem_rd;
    end
    if (pop_keep) begin
      ld_col <= q_item.col[CAW-1:0];
    end
    if (pf_rd) begin
      pf_addr <= pk[CAW-1:0];
    end
  end

  always_comb begin
    state_next = state;
    clr        = 1'b0;
    emit_rd    = 1'b0;
    empty_ld   = 1'b0;
    case (state)
      stt_pkg::B_LOAD: begin
        if (q_valid && q_item.last) begin
          state_next = ((n + CW'(q_item.keep)) == '0) ? stt_pkg::B_EMPTY
                                                      : stt_pkg::B_PREFIX;
        end
      end
      stt_pkg::B_PREFIX: begin
        if ((pk == pf_limit) && !pf_pend && !ld_wr) begin
          state_next = stt_pkg::B_SCATTER;
        end
      end
      stt_pkg::B_SCATTER: begin
        if ((sk == n) && !sc_a && !sc_b) begin
          state_next = stt_pkg::B_EMIT;
        end
      end
      stt_pkg::B_EMIT: begin
        if (ek == n) begin
          state_next = stt_pkg::B_LOAD;
          clr        = 1'b1;
        end else if (out_free) begin
          emit_rd = 1'b1;
        end
      end
      stt_pkg::B_EMPTY: begin
        if (out_free) begin
          empty_ld   = 1'b1;
          clr        = 1'b1;
          state_next = stt_pkg::B_LOAD;
        end
      end
      default: begin
        state_next = stt_pkg::B_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= stt_pkg::B_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n         <= '0;
      discard   <= 1'b0;
      ld_wr     <= 1'b0;
      pk        <= '0;
      pf_pend   <= 1'b0;
      sum       <= '0;
      sk        <= '0;
      sc_a      <= 1'b0;
      sc_b      <= 1'b0;
      ek        <= '0;
      out_valid <= 1'b0;
    end else begin
      ld_wr   <= pop_keep;
      pf_pend <= pf_rd;
      sc_a    <= (state == stt_pkg::B_SCATTER) && (sk < n);
      sc_b    <= sc_a;

      if (clr) begin
        n       <= '0;
        discard <= 1'b0;
      end else begin
        if (pop_keep) begin
          n <= n + CW'(1);
        end
        if (q_pop && !q_item.keep) begin
          discard <= 1'b1;
        end
      end

      if (state == stt_pkg::B_LOAD) begin
        pk  <= '0;
        sum <= '0;
        sk  <= '0;
        ek  <= '0;
      end else begin
        if (pf_rd) begin
          pk <= pk + PKW'(1);
        end
        if (pf_pend) begin
          sum <= sum + cnt_val;
        end
        if ((state == stt_pkg::B_SCATTER) && (sk < n)) begin
          sk <= sk + CW'(1);
        end
        if (emit_rd) begin
          ek <= ek + CW'(1);
        end
      end

      if (emit_rd || empty_ld) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- tb/sv/sparse_triplet_transpose_checker.sv -----
// Checker for the sparse triplet transpose: predicts transposed triplets and compares results.
module sparse_triplet_transpose_checker #(
  parameter int MAX_ELEMENTS = 64,
  parameter int MAX_COLUMNS  = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  logic [stt_pkg::ROW_W-1:0]        in_row,
  input  logic [stt_pkg::COL_W-1:0]        in_col,
  input  logic signed [stt_pkg::VAL_W-1:0] in_value,
  input  logic                             in_last,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  logic [stt_pkg::COL_W-1:0]        out_row,
  input  logic [stt_pkg::ROW_W-1:0]        out_col,
  input  logic signed [stt_pkg::VAL_W-1:0] out_value,
  input  logic                             out_last,
  input  logic                             dropped,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [stt_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [stt_pkg::CFG_DATA_W-1:0]   cfg_data,
  output int                               fail_count,
  output int                               pending_results,
  output int                               results_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  import stt_pkg::*;

  typedef struct packed {
    logic [COL_W-1:0]        row;
    logic [ROW_W-1:0]        col;
    logic signed [VAL_W-1:0] value;
    logic                    last;
    logic                    dropped;
  } transposed_t;

  logic [ROW_W-1:0]        row_limit;
  logic [CCOUNT_W-1:0]     col_limit;
  logic [ROW_W-1:0]        held_row [MAX_ELEMENTS];
  logic [COL_W-1:0]        held_col [MAX_ELEMENTS];
  logic signed [VAL_W-1:0] held_val [MAX_ELEMENTS];
  int                      col_tally [MAX_COLUMNS];
  int                      held_n;
  logic                    saw_discard;
  transposed_t             transposed_q [$];

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch on %s: got %h expected %h (result %0d, t=%0t)",
             what, got, want, results_checked, $realtime);
    fail_count++;
  endtask

  task automatic close_matrix();
    foreach (col_tally[k]) col_tally[k] = 0;
    held_n      = 0;
    saw_discard = 1'b0;
  endtask

  task automatic apply_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    if (idx == REG_ROW_COUNT) row_limit = data[ROW_W-1:0];
    else if (idx == REG_COLUMN_COUNT) col_limit = data[CCOUNT_W-1:0];
  endtask

  task automatic predict_triplet(input logic [ROW_W-1:0] r, input logic [COL_W-1:0] c,
                                 input logic signed [VAL_W-1:0] v, input logic l);
    int          slot [MAX_COLUMNS];
    transposed_t ordered [MAX_ELEMENTS];
    transposed_t blank;
    int          sum;
    int          p;
    if (r >= row_limit || {1'b0, c} >= col_limit || int'(c) >= MAX_COLUMNS
        || held_n >= MAX_ELEMENTS) begin
      saw_discard = 1'b1;
    end else begin
      held_row[held_n] = r;
      held_col[held_n] = c;
      held_val[held_n] = v;
      col_tally[c]++;
      held_n++;
    end
    if (!l) return;
    if (held_n == 0) begin
      blank         = '0;
      blank.dropped = 1'b1;
      transposed_q.push_back(blank);
    end else begin
      // exclusive prefix sums give the first slot of each column
      sum = 0;
      for (int k = 0; k < MAX_COLUMNS; k++) begin
        slot[k] = sum;
        sum += col_tally[k];
      end
      for (int k = 0; k < held_n; k++) begin
        p = slot[held_col[k]];
        slot[held_col[k]] = p + 1;
        ordered[p].row     = held_col[k];
        ordered[p].col     = held_row[k];
        ordered[p].value   = held_val[k];
        ordered[p].last    = (p + 1 == held_n);
        ordered[p].dropped = saw_discard;
      end
      for (int k = 0; k < held_n; k++) transposed_q.push_back(ordered[k]);
    end
    close_matrix();
  endtask

  task automatic check_result();
    transposed_t want;
    if (transposed_q.size() == 0) begin
      report_mismatch("result with none expected", 32'(out_col), 32'h0);
      return;
    end
    want = transposed_q.pop_front();
    if (out_row !== want.row) report_mismatch("out_row", 32'(out_row), 32'(want.row));
    if (out_col !== want.col) report_mismatch("out_col", 32'(out_col), 32'(want.col));
    if (out_value !== want.value) report_mismatch("out_value", out_value, want.value);
    if (out_last !== want.last) report_mismatch("out_last", 32'(out_last), 32'(want.last));
    if (dropped !== want.dropped) report_mismatch("dropped", 32'(dropped), 32'(want.dropped));
    results_checked++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      row_limit       = ROW_COUNT_RESET;
      col_limit       = COLUMN_COUNT_RESET;
      fail_count      = 0;
      results_checked = 0;
      transposed_q.delete();
      close_matrix();
    end else begin
      if (cfg_valid && cfg_ready) apply_register(cfg_index, cfg_data);
      if (out_valid && !out_stall) check_result();
      if (in_valid && !in_stall) predict_triplet(in_row, in_col, in_value, in_last);
    end
    pending_results = transposed_q.size();
  end

endmodule

// ----- tb/sv/sparse_triplet_transpose_tb.sv -----
// Testbench top for the sparse triplet transpose: stimulus, back pressure and verdict.
module sparse_triplet_transpose_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import stt_pkg::*;

  localparam int ITEM_TARGET = 470;
  localparam int PHASE_ITEMS = 80;
  localparam int SETTLE      = 100;
  localparam int IDLE_LIMIT  = 3000;

  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] REG_TOP   = '1;

  logic                    clk;
  logic                    rst;
  logic                    in_valid;
  logic                    in_stall;
  logic [ROW_W-1:0]        in_row;
  logic [COL_W-1:0]        in_col;
  logic signed [VAL_W-1:0] in_value;
  logic                    in_last;
  logic                    out_valid;
  logic                    out_stall = 1'b1;
  logic [COL_W-1:0]        out_row;
  logic [ROW_W-1:0]        out_col;
  logic signed [VAL_W-1:0] out_value;
  logic                    out_last;
  logic                    dropped;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_INDEX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_data;

  int fail_count;
  int pending_results;
  int results_checked;

  int cur_rows = 65535;
  int cur_cols = 64;
  int items_sent;
  int matrices_sent;
  int reg_writes;
  int stall_left = 0;
  int stall_draw;
  bit rx_calm;
  int idle_cycles = 0;

  sparse_triplet_transpose dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_row    (in_row),
    .in_col    (in_col),
    .in_value  (in_value),
    .in_last   (in_last),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_row   (out_row),
    .out_col   (out_col),
    .out_value (out_value),
    .out_last  (out_last),
    .dropped   (dropped),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  sparse_triplet_transpose_checker transpose_check (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_row          (in_row),
    .in_col          (in_col),
    .in_value        (in_value),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_row         (out_row),
    .out_col         (out_col),
    .out_value       (out_value),
    .out_last        (out_last),
    .dropped         (dropped),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .pending_results (pending_results),
    .results_checked (results_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side: random stall before each transaction, with calm stretches
  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b1;
      stall_left <= 0;
    end else if (out_valid && !out_stall) begin
      if ($urandom_range(0, 29) == 0) rx_calm = !rx_calm;
      stall_draw = rx_calm ? 0 : $urandom_range(0, 9);
      stall_left <= stall_draw;
      out_stall  <= (stall_draw != 0);
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= (stall_left > 1);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)
        || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_triplet(input logic [ROW_W-1:0] r, input logic [COL_W-1:0] c,
                              input logic signed [VAL_W-1:0] v, input logic l,
                              input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_row   <= r;
    in_col   <= c;
    in_value <= v;
    in_last  <= l;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (l) matrices_sent++;
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_results != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    reg_writes++;
    @(posedge clk);
  endtask

  // only called with the block idle
  task automatic set_shape(input logic [CFG_DATA_W-1:0] rows,
                           input logic [CFG_DATA_W-1:0] cols);
    wait_for_results();
    repeat (SETTLE) @(posedge clk);
    write_reg(REG_ROW_COUNT, rows);
    write_reg(REG_COLUMN_COUNT, cols);
    cur_rows = int'(rows);
    cur_cols = int'(cols[CCOUNT_W-1:0]);
  endtask

  function automatic int pick_gap(input bit calm);
    return calm ? 0 : $urandom_range(0, 9);
  endfunction

  function automatic logic [ROW_W-1:0] pick_row(input bit fit);
    if (!fit) return ROW_W'($urandom_range(cur_rows, 65535));
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return ROW_W'(cur_rows - 1);
      default: return ROW_W'($urandom_range(0, cur_rows - 1));
    endcase
  endfunction

  function automatic logic [COL_W-1:0] pick_col(input bit fit);
    if (!fit && cur_cols < COL_LIMIT) return COL_W'($urandom_range(cur_cols, COL_LIMIT - 1));
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return COL_W'(cur_cols - 1);
      default: return COL_W'($urandom_range(0, cur_cols - 1));
    endcase
  endfunction

  task automatic random_matrix(input int len, input bit noisy);
    bit calm;
    bit bad;
    bit bad_row;
    calm = ($urandom_range(0, 3) == 0);
    for (int k = 0; k < len; k++) begin
      bad     = noisy && ($urandom_range(0, 9) == 0);
      bad_row = bad && ($urandom_range(0, 1) == 0 || cur_cols >= COL_LIMIT);
      send_triplet(pick_row(!bad_row), pick_col(!(bad && !bad_row)), $urandom(),
                   k == len - 1, pick_gap(calm));
    end
  endtask

  initial begin
    int phase;
    int phase_end;
    int len;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_row    <= '0;
    in_col    <= '0;
    in_value  <= '0;
    in_last   <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset shape: extremes of the fields, one row out of range, stable order in a column
    send_triplet(16'd0, 6'd0, 32'sh7FFF_FFFF, 1'b0, pick_gap(0));
    send_triplet(16'd65534, 6'd63, 32'sh8000_0000, 1'b0, pick_gap(0));
    send_triplet(16'd65535, 6'd5, -32'sd1, 1'b0, pick_gap(0));
    send_triplet(16'd100, 6'd63, 32'sd0, 1'b0, pick_gap(0));
    send_triplet(16'd7, 6'd0, 32'sd1, 1'b1, pick_gap(0));
    // lone discarded last item: nothing stored
    send_triplet(16'd65535, 6'd0, 32'sd5, 1'b1, pick_gap(0));
    // single kept triplet
    send_triplet(16'h5AA5, 6'h2A, -32'sd5, 1'b1, 0);

    // zero rows discards everything
    set_shape(16'd0, 16'd64);
    send_triplet(16'd0, 6'd0, 32'sd1, 1'b0, pick_gap(0));
    send_triplet(16'd0, 6'd0, 32'sd2, 1'b1, pick_gap(0));

    // one by one matrix, column out of range, row out of range, spare indexes ignored
    set_shape(16'd1, 16'd1);
    write_reg(REG_SPARE, 16'hBEEF);
    write_reg(REG_TOP, 16'h1234);
    send_triplet(16'd0, 6'd0, 32'sd9, 1'b0, pick_gap(0));
    send_triplet(16'd0, 6'd1, 32'sd8, 1'b0, pick_gap(0));
    send_triplet(16'd1, 6'd0, 32'sd7, 1'b0, pick_gap(0));
    send_triplet(16'd0, 6'd0, -32'sd9, 1'b1, pick_gap(0));

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      case (phase)
        0:       set_shape(16'hFFFF, 16'h0140);  // upper bits of the column write masked off
        1:       set_shape(16'($urandom_range(1, 400)), 16'($urandom_range(1, 64)));
        2:       set_shape(16'd1, 16'd1);
        3:       set_shape(16'd65535, 16'($urandom_range(1, 63)));
        default: set_shape(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 64)));
      endcase
      if (phase == 0) random_matrix(70, 1'b0);  // overfills the store
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end && items_sent < ITEM_TARGET) begin
        len = ($urandom_range(0, 14) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 10);
        random_matrix(len, 1'b1);
        if ($urandom_range(0, 5) == 0) wait_for_results();
      end
      phase++;
    end

    wait_for_results();
    repeat (SETTLE) @(posedge clk);
    $display("covered %0d triplets in %0d matrices over %0d register writes, %0d results checked",
             items_sent, matrices_sent, reg_writes, results_checked);
    if (fail_count == 0 && pending_results == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
